### src/circular_window_class_vote_top_assert.svh
// Assertion macros for the circular window class vote block.
`ifndef CIRCULAR_WINDOW_CLASS_VOTE_TOP_ASSERT_SVH
`define CIRCULAR_WINDOW_CLASS_VOTE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CWCV_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular window class vote check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CWCV_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular window class vote check failed");

`endif

### src/cwcv_pkg.sv
// Shared constants and types of the circular window class vote block.
`timescale 1ns / 1ps

package cwcv_pkg;

    localparam int COORD_W     = 12;
    localparam int MASK_W      = 6;
    localparam int NUM_CLASSES = 6;
    localparam int COUNT_W     = 18;
    localparam int CLASS_W     = 3;
    localparam int RADIUS_W    = 8;
    localparam int RSQ_W       = 2 * RADIUS_W;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int IN_FIELDS_W = 4 * COORD_W + MASK_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CLASS_W + COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(8);
    localparam logic [RSQ_W-1:0]    RSQ_RESET    =
        RSQ_W'(RADIUS_RESET) * RSQ_W'(RADIUS_RESET);

    typedef logic [COUNT_W-1:0]     count_t;
    typedef count_t [NUM_CLASSES-1:0] counts_t;
    typedef logic [NUM_CLASSES-1:0] class_vec_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [MASK_W-1:0]  mask;
        logic               last;
    } pix_t;

    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [MASK_W-1:0]  mask;
        logic               last;
    } diff_t;

    typedef struct packed {
        logic [SQ_W-1:0]   dx_sq;
        logic [SQ_W-1:0]   dy_sq;
        logic [MASK_W-1:0] mask;
        logic              last;
    } sq_t;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

### src/cwcv_dist.sv
// Distance stages: absolute offsets, then registered squares.
`timescale 1ns / 1ps

module cwcv_dist (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cwcv_pkg::pix_t in_pix,
    output logic           out_valid,
    input  logic           out_ready,
    output cwcv_pkg::sq_t  out_sq
);

    logic            d_v_reg, d_v_next;
    cwcv_pkg::diff_t d_reg;
    cwcv_pkg::diff_t d_next;
    logic            q_v_reg, q_v_next;
    cwcv_pkg::sq_t   q_reg;
    cwcv_pkg::sq_t   q_next;
    logic            q_free;
    logic            d_move;

    assign q_free   = !q_v_reg || out_ready;
    assign d_move   = d_v_reg && q_free;
    assign in_ready = !d_v_reg || d_move;

    always_comb
    begin
        d_next.dx   = cwcv_pkg::abs_diff(in_pix.col, in_pix.sx);
        d_next.dy   = cwcv_pkg::abs_diff(in_pix.row, in_pix.sy);
        d_next.mask = in_pix.mask;
        d_next.last = in_pix.last;
        d_v_next    = in_ready ? in_valid : d_v_reg;

        q_next.dx_sq = cwcv_pkg::SQ_W'(d_reg.dx) * cwcv_pkg::SQ_W'(d_reg.dx);
        q_next.dy_sq = cwcv_pkg::SQ_W'(d_reg.dy) * cwcv_pkg::SQ_W'(d_reg.dy);
        q_next.mask  = d_reg.mask;
        q_next.last  = d_reg.last;
        q_v_next     = q_free ? d_v_reg : q_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
        end
        else
        begin
            d_v_reg <= d_v_next;
            q_v_reg <= q_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            d_reg <= d_next;
        end
        if (d_move)
        begin
            q_reg <= q_next;
        end
    end

    assign out_valid = q_v_reg;
    assign out_sq    = q_reg;

endmodule

### src/cwcv_count.sv
// Circle test, saturating class counters and end-of-window snapshot.
`timescale 1ns / 1ps

module cwcv_count (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cwcv_pkg::RSQ_W-1:0]    radius_sq,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cwcv_pkg::sq_t                 in_sq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cwcv_pkg::counts_t             out_counts
);

    cwcv_pkg::counts_t    cnt_reg, cnt_next;
    cwcv_pkg::counts_t    upd;
    cwcv_pkg::counts_t    snap_reg;
    logic                 snap_v_reg, snap_v_next;
    logic                 snap_free;
    logic                 accept;
    logic                 in_circle;
    logic [cwcv_pkg::DIST_W-1:0] dist_sq;
    cwcv_pkg::class_vec_t hit;

    assign snap_free = !snap_v_reg || out_ready;
    // A last pixel needs room in the snapshot; other pixels never wait.
    assign in_ready  = !in_sq.last || snap_free;
    assign accept    = in_valid && in_ready;

    assign dist_sq   = cwcv_pkg::DIST_W'(in_sq.dx_sq) + cwcv_pkg::DIST_W'(in_sq.dy_sq);
    assign in_circle = dist_sq <= cwcv_pkg::DIST_W'(radius_sq);
    assign hit       = cwcv_pkg::class_vec_t'(in_sq.mask)
                     & {cwcv_pkg::NUM_CLASSES{in_circle}};

    always_comb
    begin
        for (int i = 0; i < cwcv_pkg::NUM_CLASSES; i++)
        begin
            upd[i] = (hit[i] && (cnt_reg[i] != cwcv_pkg::COUNT_MAX))
                   ? cnt_reg[i] + cwcv_pkg::COUNT_W'(1) : cnt_reg[i];
        end

        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = in_sq.last ? '0 : upd;
        end

        snap_v_next = snap_v_reg;
        if (snap_v_reg && out_ready)
        begin
            snap_v_next = 1'b0;
        end
        if (accept && in_sq.last)
        begin
            snap_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            snap_v_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            snap_v_reg <= snap_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_sq.last)
        begin
            snap_reg <= upd;
        end
    end

    assign out_valid  = snap_v_reg;
    assign out_counts = snap_reg;

endmodule

### src/cwcv_vote.sv
// Winner pick over the snapshot counts and the result register.
`timescale 1ns / 1ps

module cwcv_vote (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  cwcv_pkg::counts_t                  in_counts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cwcv_pkg::OUT_DATA_W-1:0]    out_data
);

    logic                          out_v_reg, out_v_next;
    logic [cwcv_pkg::CLASS_W-1:0]  class_reg, class_next;
    cwcv_pkg::count_t              count_reg, count_next;

    assign in_ready = !out_v_reg || out_ready;

    // Scan upward; only a strictly larger count replaces the leader.
    always_comb
    begin
        class_next = '0;
        count_next = '0;
        for (int i = 0; i < cwcv_pkg::NUM_CLASSES; i++)
        begin
            if (in_counts[i] > count_next)
            begin
                count_next = in_counts[i];
                class_next = cwcv_pkg::CLASS_W'(i);
            end
        end
        out_v_next = in_ready ? in_valid : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            class_reg <= class_next;
            count_reg <= count_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = cwcv_pkg::OUT_DATA_W'({count_reg, class_reg});

endmodule

### src/circular_window_class_vote_top.sv
// Top level of the circular window class vote block.
`timescale 1ns / 1ps
// Result path: the last pixel word of a window passes the offset, square, counter
//   snapshot and vote registers before its result word is valid.
// Throughput: one pixel word per clock; the input stalls only when the output and
//   the snapshot both hold result words and another last pixel reaches the counters.
// Reset (rst_n low, asynchronous): counters clear, pipeline empties, radius returns to 8.

module circular_window_class_vote_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Pixel words in.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] pixel_col, [23:12] pixel_row, [35:24] sample_x, [47:36] sample_y,
    // [53:48] class_mask, [55:54] zero
    input  logic [cwcv_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,   // window_last
    // Vote result words out.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] best_class, [20:3] best_count, [23:21] zero
    output logic [cwcv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Radius register write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cwcv_pkg::RADIUS_W-1:0]      cfg_data
);

    logic [cwcv_pkg::RSQ_W-1:0] radius_sq_reg, radius_sq_next;
    cwcv_pkg::pix_t             pix;
    cwcv_pkg::sq_t              sq;
    logic                       sq_valid, sq_ready;
    cwcv_pkg::counts_t          counts;
    logic                       cnt_valid, cnt_ready;

    // Unpack the pixel word, lowest field first.
    assign pix.col  = s_axis_tdata[cwcv_pkg::COORD_W-1:0];
    assign pix.row  = s_axis_tdata[2*cwcv_pkg::COORD_W-1:cwcv_pkg::COORD_W];
    assign pix.sx   = s_axis_tdata[3*cwcv_pkg::COORD_W-1:2*cwcv_pkg::COORD_W];
    assign pix.sy   = s_axis_tdata[4*cwcv_pkg::COORD_W-1:3*cwcv_pkg::COORD_W];
    assign pix.mask = s_axis_tdata[cwcv_pkg::IN_FIELDS_W-1:4*cwcv_pkg::COORD_W];
    assign pix.last = s_axis_tlast;

    // Hold the squared radius so the circle test needs no multiplier per pixel.
    // The user must write only while the block is idle, so no pixel sees a change; not enforced.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        radius_sq_next = radius_sq_reg;
        if (cfg_valid && cfg_ready)
        begin
            radius_sq_next = cwcv_pkg::RSQ_W'(cfg_data) * cwcv_pkg::RSQ_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= cwcv_pkg::RSQ_RESET;
        end
        else
        begin
            radius_sq_reg <= radius_sq_next;
        end
    end

    // Stage one and two: offsets from the center, then their squares.
    cwcv_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (pix),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_sq    (sq)
    );

    // Stage three: circle test, advance counters, snapshot and clear on last.
    cwcv_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius_sq  (radius_sq_reg),
        .in_valid   (sq_valid),
        .in_ready   (sq_ready),
        .in_sq      (sq),
        .out_valid  (cnt_valid),
        .out_ready  (cnt_ready),
        .out_counts (counts)
    );

    // Stage four: pick the winner into the output register.
    cwcv_vote u_vote (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cnt_valid),
        .in_ready  (cnt_ready),
        .in_counts (counts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

### src/cwcv_checker.sv
// Port-level checks of the circular window class vote block, with bind.
`timescale 1ns / 1ps
`include "circular_window_class_vote_top_assert.svh"

module cwcv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cwcv_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [cwcv_pkg::CLASS_W-1:0] out_class;
    logic [cwcv_pkg::COUNT_W-1:0] out_count;

    assign out_class = m_axis_tdata[cwcv_pkg::CLASS_W-1:0];
    assign out_count = m_axis_tdata[cwcv_pkg::CLASS_W +: cwcv_pkg::COUNT_W];

    // A stalled result word holds.
    `CWCV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The winner index names a real class.
    `CWCV_ASSERT_NOW(a_class_range, m_axis_tvalid, out_class < cwcv_pkg::CLASS_W'(cwcv_pkg::NUM_CLASSES))

    // An empty vote reports class zero.
    `CWCV_ASSERT_NOW(a_zero_vote, m_axis_tvalid && (out_count == '0), out_class == '0)

    // Pixel input backs up only behind a result word that is stalled.
    `CWCV_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind circular_window_class_vote_top cwcv_checker u_checker (.*);

### tb/sv/circular_window_class_vote_top_tb.sv
// Self-checking testbench for the circular window class vote block.
`timescale 1ns / 1ps

module circular_window_class_vote_top_tb;

    localparam int          DRAIN_CYCLES  = 6;         // extra edges to let the pipeline empty
    localparam int          CYCLE_LIMIT   = 100_000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_PIXELS  = 150;
    localparam int          DIR_ROWS      = 20;
    localparam int          IDLE_PCT      = 24;
    localparam logic [11:0] EDGE_COORD    = 12'hFFF;

    // One vote result word, unpacked.
    typedef struct packed {
        logic [cwcv_pkg::CLASS_W-1:0] cls;
        logic [cwcv_pkg::COUNT_W-1:0] cnt;
    } vote_t;

    // One row of the directed table: a pixel word and, where pinned, its vote.
    typedef struct packed {
        logic [cwcv_pkg::COORD_W-1:0] col;
        logic [cwcv_pkg::COORD_W-1:0] row;
        logic [cwcv_pkg::COORD_W-1:0] sx;
        logic [cwcv_pkg::COORD_W-1:0] sy;
        logic [cwcv_pkg::MASK_W-1:0]  mask;
        logic                         last;
        logic                         pinned;
        logic [cwcv_pkg::CLASS_W-1:0] cls;
        logic [cwcv_pkg::COUNT_W-1:0] cnt;
    } dir_row_t;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [cwcv_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                              s_axis_tlast  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [cwcv_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [cwcv_pkg::RADIUS_W-1:0]     cfg_data      = '0;

    // Predictor state: radius register and per-class tallies.
    logic [cwcv_pkg::RADIUS_W-1:0]     radius_now    = cwcv_pkg::RADIUS_W'(8);
    logic [cwcv_pkg::COUNT_W-1:0]      tally [cwcv_pkg::NUM_CLASSES];
    vote_t                             votes_due [$];

    int                                errors        = 0;
    int                                cycles        = 0;
    bit                                tx_calm       = 1'b0;
    bit                                rx_calm       = 1'b0;

    // Directed table, run under the reset radius of 8. Votes are pinned where
    // obvious: empty windows, ties and single hits.
    dir_row_t dir_rows [DIR_ROWS] = '{
        // right after reset, pixel far outside: empty window
        '{12'd100,  12'd100,  12'd0,    12'd0,    6'h3F, 1'b1, 1'b1, 3'd0, 18'd0},
        // top corner of the coordinate range, inside
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 6'h3F, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd0,    12'd0,    12'd0,    12'd0,    6'h20, 1'b1, 1'b0, 3'd0, 18'd0},
        // on the circle: 8^2 + 0^2 == radius^2
        '{12'd8,    12'd0,    12'd0,    12'd0,    6'h01, 1'b0, 1'b0, 3'd0, 18'd0},
        // just past the circle: 8^2 + 1^2
        '{12'd4095, 12'd4094, 12'd4087, 12'd4095, 6'h02, 1'b0, 1'b0, 3'd0, 18'd0},
        // on the circle from the other side, pixel below center
        '{12'd100,  12'd92,   12'd100,  12'd100,  6'h02, 1'b0, 1'b0, 3'd0, 18'd0},
        // tie between classes 0 and 1: lower index wins
        '{12'd50,   12'd50,   12'd50,   12'd50,   6'h00, 1'b1, 1'b1, 3'd0, 18'd1},
        // opposite corners, far outside
        '{12'd0,    12'd0,    12'd4095, 12'd4095, 6'h3F, 1'b1, 1'b1, 3'd0, 18'd0},
        // inside but no class matches
        '{12'd5,    12'd5,    12'd5,    12'd5,    6'h00, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd5,    12'd5,    12'd5,    12'd5,    6'h10, 1'b1, 1'b1, 3'd4, 18'd1},
        // diagonal just outside: 6^2 + 6^2
        '{12'd6,    12'd6,    12'd0,    12'd0,    6'h04, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd7,    12'd3,    12'd2,    12'd6,    6'h04, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd2,    12'd6,    12'd7,    12'd3,    6'h0C, 1'b1, 1'b0, 3'd0, 18'd0},
        '{12'd3,    12'd3,    12'd3,    12'd3,    6'h2A, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd3,    12'd3,    12'd3,    12'd3,    6'h28, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd3,    12'd3,    12'd3,    12'd3,    6'h20, 1'b1, 1'b0, 3'd0, 18'd0},
        '{12'd4095, 12'd0,    12'd0,    12'd4095, 6'h3F, 1'b1, 1'b1, 3'd0, 18'd0},
        '{12'd0,    12'd4095, 12'd0,    12'd4095, 6'h01, 1'b1, 1'b1, 3'd0, 18'd1},
        '{12'd2048, 12'd2048, 12'd2048, 12'd2040, 6'h3F, 1'b0, 1'b0, 3'd0, 18'd0},
        '{12'd2040, 12'd2048, 12'd2048, 12'd2048, 6'h15, 1'b1, 1'b0, 3'd0, 18'd0}
    };

    circular_window_class_vote_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case a word never arrives.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("circular_window_class_vote_top_tb failed");
            $finish;
        end
    end

    // Count one pixel into the tallies; on the window's last pixel, vote and
    // clear. Returns 1 when a result word is due.
    function automatic bit tally_pixel(input cwcv_pkg::pix_t p, output vote_t v);
        logic [cwcv_pkg::COORD_W-1:0] dx;
        logic [cwcv_pkg::COORD_W-1:0] dy;
        int unsigned                  dist_sq;
        int unsigned                  rsq;
        dx      = (p.col >= p.sx) ? p.col - p.sx : p.sx - p.col;
        dy      = (p.row >= p.sy) ? p.row - p.sy : p.sy - p.row;
        dist_sq = 32'(dx) * 32'(dx) + 32'(dy) * 32'(dy);
        rsq     = 32'(radius_now) * 32'(radius_now);
        v       = '0;
        if (dist_sq <= rsq)
        begin
            for (int i = 0; i < cwcv_pkg::NUM_CLASSES; i++)
            begin
                // hold at full scale
                if (p.mask[i] && tally[i] != cwcv_pkg::COUNT_MAX)
                    tally[i] = tally[i] + cwcv_pkg::COUNT_W'(1);
            end
        end
        if (!p.last)
            return 1'b0;
        // strictly greater replaces, so ties keep the lower class
        for (int i = 0; i < cwcv_pkg::NUM_CLASSES; i++)
        begin
            if (tally[i] > v.cnt)
            begin
                v.cnt = tally[i];
                v.cls = cwcv_pkg::CLASS_W'(i);
            end
        end
        for (int i = 0; i < cwcv_pkg::NUM_CLASSES; i++)
            tally[i] = '0;
        return 1'b1;
    endfunction

    // Pick a coordinate near a center, clipped to the coordinate range.
    function automatic logic [cwcv_pkg::COORD_W-1:0] near_coord(
        input logic [cwcv_pkg::COORD_W-1:0] c,
        input int span
    );
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > int'(EDGE_COORD))
            v = int'(EDGE_COORD);
        return cwcv_pkg::COORD_W'(v);
    endfunction

    function automatic logic [cwcv_pkg::COORD_W-1:0] pick_center();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? EDGE_COORD : '0;
        return cwcv_pkg::COORD_W'($urandom_range(4095));
    endfunction

    // Present one pixel word and wait for the handshake; pinned votes replace
    // the predicted one.
    task automatic send_pixel(input cwcv_pkg::pix_t p, input bit pinned,
                              input vote_t pinned_vote);
        vote_t v;
        if (!tx_calm)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cwcv_pkg::IN_DATA_W'({p.mask, p.sy, p.sx, p.row, p.col});
        s_axis_tlast  <= p.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (tally_pixel(p, v))
            votes_due = {votes_due, (pinned ? pinned_vote : v)};
    endtask

    // Drop valid, wait for every due vote, then let the pipeline empty.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (votes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the radius register on an idle block.
    task automatic write_radius(input logic [cwcv_pkg::RADIUS_W-1:0] r);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        radius_now  = r;
    endtask

    // Result side: random backpressure, quiet during calm phases.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every accepted result word with the oldest due vote.
    always @(posedge clk)
    begin : check_votes
        vote_t got;
        vote_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.cls = m_axis_tdata[cwcv_pkg::CLASS_W-1:0];
            got.cnt = m_axis_tdata[cwcv_pkg::CLASS_W +: cwcv_pkg::COUNT_W];
            if (votes_due.size() == 0)
            begin
                $error("unexpected result word: best_class %0d best_count %0d",
                       got.cls, got.cnt);
                errors++;
            end
            else
            begin
                want = votes_due.pop_front();
                if (got.cls !== want.cls)
                begin
                    $error("best_class: expected %0d, got %0d", want.cls, got.cls);
                    errors++;
                end
                if (got.cnt !== want.cnt)
                begin
                    $error("best_count: expected %0d, got %0d", want.cnt, got.cnt);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        cwcv_pkg::pix_t                px;
        logic [cwcv_pkg::COORD_W-1:0]  cx;
        logic [cwcv_pkg::COORD_W-1:0]  cy;
        logic [cwcv_pkg::RADIUS_W-1:0] r;
        int                            len;
        int                            sent;
        bit                            noise;

        for (int i = 0; i < cwcv_pkg::NUM_CLASSES; i++)
            tally[i] = '0;

        // Hold reset, then release it on an edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            px = '{dir_rows[i].col, dir_rows[i].row, dir_rows[i].sx, dir_rows[i].sy,
                   dir_rows[i].mask, dir_rows[i].last};
            send_pixel(px, dir_rows[i].pinned, '{dir_rows[i].cls, dir_rows[i].cnt});
        end

        // Random phases, each under its own radius: both extremes, one, the
        // reset value, then random values. Phase 2 runs with no idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       r = '0;
                1:       r = '1;
                2:       r = cwcv_pkg::RADIUS_W'(1);
                3:       r = cwcv_pkg::RADIUS_W'(8);
                default: r = cwcv_pkg::RADIUS_W'($urandom_range(255));
            endcase
            write_radius(r);
            tx_calm  = (ph == 2);
            rx_calm <= (ph == 2);
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                len   = $urandom_range(1, 24);
                noise = ($urandom_range(99) < 15);
                cx    = pick_center();
                cy    = pick_center();
                for (int k = 0; k < len; k++)
                begin
                    if (noise)
                    begin
                        // arbitrary pixels, stray centers, broken window ends
                        px.col  = cwcv_pkg::COORD_W'($urandom_range(4095));
                        px.row  = cwcv_pkg::COORD_W'($urandom_range(4095));
                        px.sx   = pick_center();
                        px.sy   = pick_center();
                        px.last = ($urandom_range(3) == 0);
                    end
                    else
                    begin
                        // well-formed window: pixels straddle the circle edge
                        px.sx   = cx;
                        px.sy   = cy;
                        px.col  = near_coord(cx, int'(radius_now) + 2);
                        px.row  = near_coord(cy, int'(radius_now) + 2);
                        px.last = (k == len - 1);
                    end
                    px.mask = cwcv_pkg::MASK_W'($urandom_range(63));
                    send_pixel(px, 1'b0, '0);
                    sent++;
                end
                // now and then hold the sender until every vote is back
                if ($urandom_range(9) == 0)
                    wait_drained();
            end
        end
        tx_calm  = 1'b0;
        rx_calm <= 1'b0;

        wait_drained();
        if (errors == 0 && votes_due.size() == 0)
            $display("circular_window_class_vote_top_tb passed");
        else
            $display("circular_window_class_vote_top_tb failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/cwcv_pkg.sv
src/cwcv_dist.sv
src/cwcv_count.sv
src/cwcv_vote.sv
src/circular_window_class_vote_top.sv
src/cwcv_checker.sv
tb/sv/circular_window_class_vote_top_tb.sv
